>>> sv/mte_pkg.sv
// shared types, key codes and character tables for the multi-tap text entry unit
`timescale 1ns / 1ps
`default_nettype none
package mte_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DRAIN
  } state_t;

  localparam logic [2:0] ACT_APPEND  = 3'd0;
  localparam logic [2:0] ACT_REPLACE = 3'd1;
  localparam logic [2:0] ACT_DELETE  = 3'd2;
  localparam logic [2:0] ACT_MODE    = 3'd3;
  localparam logic [2:0] ACT_CASE    = 3'd4;
  localparam logic [2:0] ACT_IGNORE  = 3'd5;
  localparam logic [2:0] ACT_EXIT    = 3'd6;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_KEY  = 1'b1;

  localparam logic [3:0] KEY_A    = 4'd3;
  localparam logic [3:0] KEY_B    = 4'd7;
  localparam logic [3:0] KEY_C    = 4'd11;
  localparam logic [3:0] KEY_STAR = 4'd12;
  localparam logic [3:0] KEY_HASH = 4'd14;
  localparam logic [3:0] KEY_D    = 4'd15;

  localparam logic [1:0] EXIT_NONE = 2'd0;
  localparam logic [1:0] EXIT_B    = 2'd1;
  localparam logic [1:0] EXIT_C    = 2'd2;
  localparam logic [1:0] EXIT_D    = 2'd3;

  localparam int STREAM_MAX = 32;

  localparam logic [0:0] REG_TIMEOUT = 1'd0;
  localparam logic [0:0] REG_MAX_LEN = 1'd1;

  typedef struct packed {
    logic [4:0] pad;
    logic [1:0] exit_key;
    logic       cycling;
    logic       upper_case;
    logic       alpha_mode;
    logic [5:0] text_length;
    logic [4:0] position;
    logic [7:0] char_value;
    logic [2:0] action;
  } out_word_t;

  function automatic logic [7:0] key_char(input logic [3:0] k);
    logic [7:0] c;
    case (k)
      4'd0:    c = "1";
      4'd1:    c = "2";
      4'd2:    c = "3";
      4'd3:    c = "A";
      4'd4:    c = "4";
      4'd5:    c = "5";
      4'd6:    c = "6";
      4'd7:    c = "B";
      4'd8:    c = "7";
      4'd9:    c = "8";
      4'd10:   c = "9";
      4'd11:   c = "C";
      4'd12:   c = "*";
      4'd13:   c = "0";
      4'd14:   c = "#";
      default: c = "D";
    endcase
    return c;
  endfunction

  function automatic logic key_is_digit(input logic [3:0] k);
    logic [7:0] c;
    c = key_char(k);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic [3:0] key_digit(input logic [3:0] k);
    logic [7:0] c;
    c = key_char(k) - 8'd48;
    return c[3:0];
  endfunction

  function automatic logic [1:0] exit_code(input logic [3:0] k);
    logic [1:0] e;
    case (k)
      KEY_B:   e = EXIT_B;
      KEY_C:   e = EXIT_C;
      KEY_D:   e = EXIT_D;
      default: e = EXIT_NONE;
    endcase
    return e;
  endfunction

  function automatic logic [4:0] group_len(input logic [3:0] d);
    logic [4:0] n;
    case (d)
      4'd0:    n = 5'd1;
      4'd1:    n = 5'd16;
      4'd7:    n = 5'd4;
      4'd9:    n = 5'd4;
      default: n = 5'd3;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] group_char(input logic [3:0] d, input logic [3:0] tap);
    logic [7:0] c;
    logic [7:0] base;
    c = " ";
    base = " ";
    case (d)
      4'd1: begin
        case (tap)
          4'd0:    c = "-";
          4'd1:    c = ",";
          4'd2:    c = ".";
          4'd3:    c = "!";
          4'd4:    c = "?";
          4'd5:    c = "+";
          4'd6:    c = "/";
          4'd7:    c = "@";
          4'd8:    c = "#";
          4'd9:    c = "$";
          4'd10:   c = "%";
          4'd11:   c = "^";
          4'd12:   c = "&";
          4'd13:   c = "*";
          4'd14:   c = "(";
          default: c = ")";
        endcase
      end
      4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7: begin
        base = 8'd65 + 8'({d - 4'd2, 1'b0}) + 8'(d - 4'd2);
        c = base + 8'(tap);
      end
      4'd8: begin
        c = 8'd84 + 8'(tap);
      end
      4'd9: begin
        c = 8'd87 + 8'(tap);
      end
      default: c = " ";
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

>>> sv/mte_ram.sv
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps
`default_nettype none
module mte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire                                     clk,
  input  wire                                     wr_en,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire  [WIDTH-1:0]                        wr_data,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> sv/multitap_text_entry_unit.sv
// multi-tap keypad text entry: key handling, text store and exit streaming
// tick word: applied at the accepting edge, no result
// key word: result registered in exec once the output is free; no new word taken meanwhile
// exit key: first read at the accepting edge, then one word per cycle while the output is free
// the text store ram has a registered read port; an empty text exits with one zero word
// reset empties the text, resets modes, timer, config; store undefined, no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module multitap_text_entry_unit #(
  parameter int MAX_LEN    = 32,
  parameter int TIMER_BITS = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // key_code[3:0], zero fill
  input  wire         s_tuser,   // req_type
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [31:0] m_tdata,   // action, char_value, position, text_length, alpha_mode,
                                 // upper_case, cycling, exit_key, zero fill
  output logic        m_tlast,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire         cfg_index,
  input  wire  [15:0] cfg_data
);

  localparam int AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int XW    = (CNT_W > 6) ? CNT_W : 6;
  localparam int TW    = TIMER_BITS + 1;
  localparam int CW    = (TW > 16) ? TW : 16;
  localparam logic [TW-1:0] TICK_SAT = {1'b1, {TIMER_BITS{1'b0}}};

  mte_pkg::state_t state;
  mte_pkg::state_t state_next;

  logic [15:0]      repeat_window;
  logic [5:0]       max_len;
  logic [CNT_W-1:0] count;
  logic [3:0]       tap;
  logic             letters_on;
  logic             caps_on;
  logic [3:0]       prev_key;
  logic [TW-1:0]    ticks;
  logic [5:0]       dp;
  logic [5:0]       drain_n;
  logic [1:0]       drain_ex;
  logic [3:0]       key_q;

  logic [3:0]       key_in;
  logic             in_accept;
  logic             out_free;
  logic             out_push;
  logic             drain_last;
  logic             expired;
  logic [XW-1:0]    count_x;
  logic [XW-1:0]    lim_x;

  logic [AW-1:0]    rd_addr;
  logic [7:0]       rd_data;
  logic             wr_en;

  // execute results
  logic [2:0]       ex_act;
  logic [7:0]       ex_ch;
  logic [XW-1:0]    ex_pos;
  logic [XW-1:0]    count_next;
  logic [3:0]       tap_next;
  logic             letters_next;
  logic             caps_next;
  logic             ex_wr;
  logic [3:0]       ex_digit;
  logic [3:0]       tap_inc;
  logic [7:0]       ex_raw;

  mte_pkg::out_word_t out_word;
  logic               out_last;
  mte_pkg::out_word_t m_word;

  assign key_in    = s_tdata[3:0];
  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign cfg_ready = !rst;
  assign count_x   = XW'(count);
  assign lim_x     = (XW'(max_len) < XW'(MAX_LEN)) ? XW'(max_len) : XW'(MAX_LEN);
  assign expired   = ticks[TIMER_BITS] || (CW'(ticks) > CW'(repeat_window));
  assign drain_last = (drain_n == 6'd0) || (6'(dp + 6'd1) == drain_n);
  assign m_word    = mte_pkg::out_word_t'(m_tdata);

  mte_ram #(
    .WIDTH(8),
    .DEPTH(MAX_LEN)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(AW'(ex_pos)),
    .wr_data(ex_ch),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // key execution
  always_comb begin
    ex_act       = mte_pkg::ACT_IGNORE;
    ex_ch        = 8'd0;
    ex_pos       = '0;
    count_next   = count_x;
    tap_next     = tap;
    letters_next = letters_on;
    caps_next    = caps_on;
    ex_wr        = 1'b0;
    ex_digit     = mte_pkg::key_digit(key_q);
    tap_inc      = tap + 4'd1;
    ex_raw       = 8'd0;
    case (key_q)
      mte_pkg::KEY_A: begin
        if (count_x != '0) begin
          count_next = count_x - XW'(1);
          ex_ch      = rd_data;
          ex_pos     = count_x - XW'(1);
          ex_act     = mte_pkg::ACT_DELETE;
        end
      end
      mte_pkg::KEY_STAR: begin
        letters_next = !letters_on;
        ex_act       = mte_pkg::ACT_MODE;
      end
      mte_pkg::KEY_HASH: begin
        caps_next = !caps_on;
        ex_act    = mte_pkg::ACT_CASE;
      end
      default: begin
        if (letters_on) begin
          if (expired || (key_q != prev_key)) begin
            if (count_x < lim_x) begin
              tap_next   = 4'd0;
              ex_raw     = mte_pkg::group_char(ex_digit, 4'd0);
              ex_pos     = count_x;
              count_next = count_x + XW'(1);
              ex_wr      = 1'b1;
              ex_act     = mte_pkg::ACT_APPEND;
            end
          end else if (count_x != '0) begin
            tap_next = (5'(tap_inc) >= mte_pkg::group_len(ex_digit)) ? 4'd0 : tap_inc;
            ex_raw   = mte_pkg::group_char(ex_digit, tap_next);
            ex_pos   = count_x - XW'(1);
            ex_wr    = 1'b1;
            ex_act   = mte_pkg::ACT_REPLACE;
          end
          if (!caps_on && ex_raw >= "A" && ex_raw <= "Z") begin
            ex_ch = ex_raw + 8'd32;
          end else begin
            ex_ch = ex_raw;
          end
        end else if (count_x < lim_x) begin
          ex_ch      = mte_pkg::key_char(key_q);
          ex_pos     = count_x;
          count_next = count_x + XW'(1);
          ex_wr      = 1'b1;
          ex_act     = mte_pkg::ACT_APPEND;
        end
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mte_pkg::ST_IDLE: begin
        if (s_tvalid && s_tuser == mte_pkg::REQ_KEY) begin
          if (mte_pkg::exit_code(key_in) != mte_pkg::EXIT_NONE) begin
            state_next = mte_pkg::ST_DRAIN;
          end else begin
            state_next = mte_pkg::ST_EXEC;
          end
        end
      end
      mte_pkg::ST_EXEC: begin
        if (out_free) begin
          state_next = mte_pkg::ST_IDLE;
        end
      end
      mte_pkg::ST_DRAIN: begin
        if (out_free && drain_last) begin
          state_next = mte_pkg::ST_IDLE;
        end
      end
      default: state_next = mte_pkg::ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    s_tready = 1'b0;
    out_push = 1'b0;
    wr_en    = 1'b0;
    rd_addr  = AW'(count - CNT_W'(1));
    out_word = '0;
    out_last = 1'b1;
    case (state)
      mte_pkg::ST_IDLE: begin
        s_tready = !rst;
        if (mte_pkg::exit_code(key_in) != mte_pkg::EXIT_NONE) begin
          rd_addr = '0;
        end
      end
      mte_pkg::ST_EXEC: begin
        out_push             = out_free;
        wr_en                = out_free && ex_wr;
        out_word.action      = ex_act;
        out_word.char_value  = ex_ch;
        out_word.position    = ex_pos[4:0];
        out_word.text_length = count_next[5:0];
        out_word.alpha_mode  = letters_next;
        out_word.upper_case  = caps_next;
        out_word.cycling     = letters_next && (count_next != '0) &&
                               mte_pkg::key_is_digit(key_q);
        out_word.exit_key    = mte_pkg::EXIT_NONE;
        out_last             = 1'b1;
        rd_addr              = AW'(count_x - XW'(1));
      end
      mte_pkg::ST_DRAIN: begin
        out_push             = out_free;
        rd_addr              = out_free ? AW'(6'(dp + 6'd1)) : AW'(dp);
        out_word.action      = mte_pkg::ACT_EXIT;
        out_word.char_value  = (drain_n == 6'd0) ? 8'd0 : rd_data;
        out_word.position    = dp[4:0];
        out_word.text_length = 6'd0;
        out_word.alpha_mode  = 1'b1;
        out_word.upper_case  = 1'b1;
        out_word.cycling     = 1'b0;
        out_word.exit_key    = drain_ex;
        out_last             = drain_last;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= mte_pkg::ST_IDLE;
      repeat_window <= 16'd1000;
      max_len       <= 6'd32;
      count         <= '0;
      tap           <= 4'd0;
      letters_on    <= 1'b1;
      caps_on       <= 1'b1;
      prev_key      <= 4'd0;
      ticks         <= TICK_SAT;
      dp            <= 6'd0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == mte_pkg::REG_TIMEOUT) begin
          repeat_window <= cfg_data;
        end else begin
          max_len <= cfg_data[5:0];
        end
      end
      if (in_accept) begin
        if (s_tuser == mte_pkg::REQ_TICK) begin
          if (!ticks[TIMER_BITS]) begin
            ticks <= ticks + TW'(1);
          end
        end else if (mte_pkg::exit_code(key_in) != mte_pkg::EXIT_NONE) begin
          count      <= '0;
          tap        <= 4'd0;
          letters_on <= 1'b1;
          caps_on    <= 1'b1;
          ticks      <= TICK_SAT;
          dp         <= 6'd0;
        end
      end
      if (state == mte_pkg::ST_EXEC && out_free) begin
        count      <= CNT_W'(count_next);
        tap        <= tap_next;
        letters_on <= letters_next;
        caps_on    <= caps_next;
        prev_key   <= key_q;
        if (mte_pkg::key_is_digit(key_q)) begin
          ticks <= '0;
        end
      end
      if (state == mte_pkg::ST_DRAIN && out_free) begin
        dp <= 6'(dp + 6'd1);
      end
      if (out_push) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      key_q    <= key_in;
      drain_n  <= (count_x < XW'(mte_pkg::STREAM_MAX)) ? 6'(count_x)
                                                      : 6'(mte_pkg::STREAM_MAX);
      drain_ex <= mte_pkg::exit_code(key_in);
    end
    if (out_push) begin
      m_tdata <= out_word;
      m_tlast <= out_last;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    XW'(count) <= XW'(MAX_LEN))
    else $error("text count beyond store depth");

  a_ticks_sat: assert property (@(posedge clk) disable iff (rst)
    ticks <= TICK_SAT)
    else $error("tick counter beyond saturation");

  a_drain_ptr: assert property (@(posedge clk) disable iff (rst)
    (state == mte_pkg::ST_DRAIN && drain_n != 6'd0) |-> (dp < drain_n))
    else $error("drain pointer past text end");

  a_drain_done: assert property (@(posedge clk) disable iff (rst)
    (state == mte_pkg::ST_DRAIN && out_free && drain_last) |=>
    (state == mte_pkg::ST_IDLE && m_tvalid && m_tlast))
    else $error("drain did not finish with a last word");

  a_exit_cleared: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_word.exit_key != mte_pkg::EXIT_NONE) |->
    (m_word.text_length == 6'd0 && m_word.action == mte_pkg::ACT_EXIT))
    else $error("exit word without cleared session");

endmodule
`default_nettype wire

>>> tb/multitap_text_entry_unit_tb.sv
// testbench for the multi-tap text entry unit: directed and random key streams
`timescale 1ns / 1ps
module multitap_text_entry_unit_tb;

  localparam int STORE_DEPTH = 32;
  localparam int TICK_SAT    = 1 << 16;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    mte_pkg::out_word_t word;
    logic               last;
  } keypad_result_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic [7:0]  s_tdata   = 8'd0;
  logic        s_tuser   = 1'b0;
  logic        m_tready  = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data  = 16'd0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [31:0] m_tdata;
  wire         m_tlast;
  wire         cfg_ready;

  multitap_text_entry_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predicted state of the keypad session
  string          keypad_layout = "123A456B789C*0#D";
  logic [7:0]     text_mem [STORE_DEPTH];
  int unsigned    txt_len;
  int unsigned    tap_pos;
  logic           letters;
  logic           caps;
  logic [3:0]     prev_key;
  int unsigned    idle_ticks;
  int unsigned    timeout_r;
  int unsigned    maxlen_r;

  keypad_result_t pending_results [$];
  int             mismatches  = 0;
  int             cycle_count = 0;
  int             gap_pct     = 0;
  int             stall_pct   = 0;
  int             hold_req    = 0;
  int             hold_left   = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic string letter_set(int d);
    case (d)
      0:       return " ";
      1:       return "-,.!?+/@#$%^&*()";
      2:       return "ABC";
      3:       return "DEF";
      4:       return "GHI";
      5:       return "JKL";
      6:       return "MNO";
      7:       return "PQRS";
      8:       return "TUV";
      default: return "WXYZ";
    endcase
  endfunction

  function automatic int digit_val(logic [3:0] key);
    byte c;
    c = keypad_layout[key];
    if (c >= "0" && c <= "9") return c - "0";
    return -1;
  endfunction

  function automatic logic [3:0] key_for_digit(int d);
    for (int k = 0; k < 16; k++)
      if (digit_val(4'(k)) == d) return 4'(k);
    return 4'd0;
  endfunction

  function automatic logic timed_out();
    return idle_ticks >= TICK_SAT || idle_ticks > timeout_r;
  endfunction

  function automatic int unsigned len_limit();
    return maxlen_r < STORE_DEPTH ? maxlen_r : STORE_DEPTH;
  endfunction

  function automatic logic [7:0] tap_letter(int d, int unsigned t);
    string s;
    logic [7:0] c;
    s = letter_set(d);
    c = s[t % s.len()];
    if (!caps && c >= "A" && c <= "Z") c = c + 8'd32;
    return c;
  endfunction

  function automatic void push_result(logic [2:0] act, logic [7:0] ch, int unsigned pos,
                                      logic [1:0] ex, logic fin);
    keypad_result_t r;
    r.word             = '0;
    r.word.action      = act;
    r.word.char_value  = ch;
    r.word.position    = pos[4:0];
    r.word.text_length = txt_len[5:0];
    r.word.alpha_mode  = letters;
    r.word.upper_case  = caps;
    r.word.cycling     = letters && txt_len > 0 && !timed_out() && digit_val(prev_key) >= 0;
    r.word.exit_key    = ex;
    r.last             = fin;
    pending_results.push_back(r);
  endfunction

  function automatic void clear_session();
    txt_len    = 0;
    tap_pos    = 0;
    letters    = 1'b1;
    caps       = 1'b1;
    idle_ticks = TICK_SAT;
  endfunction

  function automatic void predict_keypad(logic req, logic [3:0] key);
    logic [7:0]  drained [STORE_DEPTH];
    logic [7:0]  ch;
    logic [2:0]  act;
    logic [1:0]  ex;
    int unsigned pos;
    int unsigned n;
    int          d;
    string       grp;
    act = mte_pkg::ACT_IGNORE;
    ch  = 8'd0;
    pos = 0;
    if (req == mte_pkg::REQ_TICK) begin
      if (idle_ticks < TICK_SAT) idle_ticks++;
      return;
    end
    if (key == mte_pkg::KEY_B || key == mte_pkg::KEY_C || key == mte_pkg::KEY_D) begin
      ex = (key == mte_pkg::KEY_B) ? mte_pkg::EXIT_B :
           (key == mte_pkg::KEY_C) ? mte_pkg::EXIT_C : mte_pkg::EXIT_D;
      n = txt_len < mte_pkg::STREAM_MAX ? txt_len : mte_pkg::STREAM_MAX;
      for (int k = 0; k < n; k++) drained[k] = text_mem[k];
      clear_session();
      if (n == 0) begin
        push_result(mte_pkg::ACT_EXIT, 8'd0, 0, ex, 1'b1);
      end else begin
        for (int k = 0; k < n; k++)
          push_result(mte_pkg::ACT_EXIT, drained[k], k, ex, k == n - 1);
      end
      return;
    end
    if (key == mte_pkg::KEY_A) begin
      if (txt_len > 0) begin
        txt_len--;
        ch  = text_mem[txt_len];
        pos = txt_len;
        act = mte_pkg::ACT_DELETE;
      end
    end else if (key == mte_pkg::KEY_STAR) begin
      letters = !letters;
      act = mte_pkg::ACT_MODE;
    end else if (key == mte_pkg::KEY_HASH) begin
      caps = !caps;
      act = mte_pkg::ACT_CASE;
    end else begin
      d = digit_val(key);
      if (letters) begin
        if (timed_out() || key != prev_key) begin
          if (txt_len < len_limit()) begin
            tap_pos = 0;
            ch = tap_letter(d, 0);
            pos = txt_len;
            text_mem[txt_len] = ch;
            txt_len++;
            act = mte_pkg::ACT_APPEND;
          end
        end else if (txt_len > 0) begin
          grp = letter_set(d);
          tap_pos = (tap_pos + 1) & 15;
          if (tap_pos >= grp.len()) tap_pos = 0;
          ch = tap_letter(d, tap_pos);
          pos = txt_len - 1;
          text_mem[pos] = ch;
          act = mte_pkg::ACT_REPLACE;
        end
      end else if (txt_len < len_limit()) begin
        ch = keypad_layout[key];
        pos = txt_len;
        text_mem[txt_len] = ch;
        txt_len++;
        act = mte_pkg::ACT_APPEND;
      end
      idle_ticks = 0;
    end
    prev_key = key;
    push_result(act, ch, pos, mte_pkg::EXIT_NONE, 1'b1);
  endfunction

  function automatic void cmp_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    keypad_result_t     want;
    mte_pkg::out_word_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = mte_pkg::out_word_t'(m_tdata);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word expected none actual %h last %b", $time, m_tdata,
                 m_tlast);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        cmp_field("action", want.word.action, got.action);
        cmp_field("char_value", want.word.char_value, got.char_value);
        cmp_field("position", want.word.position, got.position);
        cmp_field("text_length", want.word.text_length, got.text_length);
        cmp_field("alpha_mode", want.word.alpha_mode, got.alpha_mode);
        cmp_field("upper_case", want.word.upper_case, got.upper_case);
        cmp_field("cycling", want.word.cycling, got.cycling);
        cmp_field("exit_key", want.word.exit_key, got.exit_key);
        cmp_field("last", want.last, m_tlast);
      end
    end
  end

  // receiver stalls, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_word(logic req, logic [3:0] key);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {4'd0, key};
    do @(posedge clk); while (!s_tready);
    predict_keypad(req, key);
  endtask

  task automatic press(logic [3:0] key);
    send_word(mte_pkg::REQ_KEY, key);
  endtask

  task automatic tap_digit(int d, int times = 1);
    repeat (times) press(key_for_digit(d));
  endtask

  task automatic tick(int n);
    repeat (n) send_word(mte_pkg::REQ_TICK, 4'($urandom_range(15)));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == mte_pkg::REG_TIMEOUT) timeout_r = val;
    else maxlen_r = val[5:0];
  endtask

  task automatic test_letter_entry();
    tap_digit(2, 4);
    tap_digit(7, 5);
    press(mte_pkg::KEY_HASH);
    tap_digit(9);
    tap_digit(1, 17);
    tap_digit(0, 2);
    press(mte_pkg::KEY_A);
    press(mte_pkg::KEY_B);
    wait_drained();
  endtask

  task automatic test_digit_mode();
    press(mte_pkg::KEY_STAR);
    for (int d = 0; d < 10; d++) tap_digit(d);
    press(mte_pkg::KEY_HASH);
    tap_digit(5, 2);
    press(mte_pkg::KEY_A);
    press(mte_pkg::KEY_C);
    press(mte_pkg::KEY_D);
    wait_drained();
  endtask

  task automatic test_store_limits();
    write_reg(mte_pkg::REG_MAX_LEN, 16'd0);
    tap_digit(2, 2);
    press(mte_pkg::KEY_A);
    tap_digit(3);
    write_reg(mte_pkg::REG_MAX_LEN, 16'd3);
    tap_digit(4);
    tap_digit(5);
    tap_digit(6);
    tap_digit(9, 2);
    press(mte_pkg::KEY_D);
    write_reg(mte_pkg::REG_MAX_LEN, 16'd63);
    for (int i = 0; i < STORE_DEPTH + 1; i++) tap_digit(2 + (i % 8));
    press(mte_pkg::KEY_B);
    wait_drained();
  endtask

  task automatic test_timeout();
    write_reg(mte_pkg::REG_TIMEOUT, 16'd0);
    tap_digit(2, 2);
    tick(1);
    tap_digit(2);
    write_reg(mte_pkg::REG_TIMEOUT, 16'd2);
    tap_digit(3);
    tick(2);
    tap_digit(3);
    tick(3);
    tap_digit(3);
    press(mte_pkg::KEY_D);
    wait_drained();
  endtask

  // an exit saturates the timer, so the same key appends even with the widest window
  task automatic test_timer_saturation();
    write_reg(mte_pkg::REG_TIMEOUT, 16'hFFFF);
    tap_digit(8);
    press(mte_pkg::KEY_C);
    tap_digit(8);
    tick(3);
    tap_digit(8);
    press(mte_pkg::KEY_C);
    wait_drained();
  endtask

  task automatic test_backpressure();
    write_reg(mte_pkg::REG_TIMEOUT, 16'd1000);
    write_reg(mte_pkg::REG_MAX_LEN, 16'd32);
    gap_pct   = 0;
    stall_pct = 0;
    hold_req  = 300;
    for (int i = 0; i < 20; i++) tap_digit(i % 10);
    press(mte_pkg::KEY_D);
    wait_drained();
  endtask

  task automatic run_random(int n_keys);
    int sent;
    int d;
    int r;
    sent = 0;
    while (sent < n_keys) begin
      r = $urandom_range(99);
      if (r < 60) begin
        d = $urandom_range(9);
        repeat ($urandom_range(1, 5)) begin
          tap_digit(d);
          sent++;
          if ($urandom_range(9) == 0 && timeout_r < 8) tick(timeout_r + 1);
          else tick($urandom_range(0, timeout_r < 4 ? timeout_r : 4));
        end
        if ($urandom_range(1) == 0 && timeout_r < 8) tick(timeout_r + 1);
      end else if (r < 70) begin
        press(mte_pkg::KEY_A);
        sent++;
      end else if (r < 77) begin
        press(mte_pkg::KEY_STAR);
        sent++;
      end else if (r < 83) begin
        press(mte_pkg::KEY_HASH);
        sent++;
      end else if (r < 90) begin
        case ($urandom_range(2))
          0:       press(mte_pkg::KEY_B);
          1:       press(mte_pkg::KEY_C);
          default: press(mte_pkg::KEY_D);
        endcase
        sent++;
      end else begin
        r = $urandom_range(1);
        send_word(r[0], 4'($urandom_range(15)));
        if (r[0] == mte_pkg::REQ_KEY) sent++;
      end
    end
    wait_drained();
  endtask

  task automatic run_phase(int gap, int stall, logic [15:0] tmo, logic [5:0] mlen, int n);
    write_reg(mte_pkg::REG_TIMEOUT, tmo);
    write_reg(mte_pkg::REG_MAX_LEN, 16'(mlen));
    gap_pct   = gap;
    stall_pct = stall;
    run_random(n);
  endtask

  initial begin
    timeout_r = 1000;
    maxlen_r  = 32;
    prev_key  = 4'd0;
    clear_session();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    gap_pct   = 23;
    stall_pct = 23;
    test_letter_entry();
    test_digit_mode();
    test_store_limits();
    test_timeout();
    gap_pct   = 0;
    stall_pct = 0;
    test_timer_saturation();
    test_backpressure();
    run_phase(0, 0, 16'($urandom_range(0, 3)), 6'd40, 10);
    run_phase(66, 0, 16'($urandom_range(1, 6)), 6'($urandom_range(2, 6)), 10);
    run_phase(0, 66, 16'($urandom_range(0, 6)), 6'd32, 10);
    run_phase(23, 23, 16'hFFFF, 6'($urandom_range(1, 31)), 10);
    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
